/* hdl/rtfp_pkg.sv */
// Package for the radar TLV frame parser.
// Holds the parse phase type, the record and limits structs and the fixed constants; no dependencies.
`default_nettype none
package rtfp_pkg;
	localparam int HEADER_BYTES = 40;
	localparam int TLV_HEADER_BYTES = 8;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_HUNT     = 3'd0,
		PH_HEADER   = 3'd1,
		PH_TLV_HEAD = 3'd2,
		PH_TLV_BODY = 3'd3,
		PH_SKIP     = 3'd4
	} phase_t;

	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_POSITION = 2'd1;
	localparam logic [1:0] KIND_SNR      = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LIMITS = 2'd1;
	localparam logic [1:0] ERR_TLV    = 2'd2;

	localparam logic [2:0] REG_SYNC_LOW    = 3'd0;
	localparam logic [2:0] REG_SYNC_HIGH   = 3'd1;
	localparam logic [2:0] REG_MAX_PAYLOAD = 3'd2;
	localparam logic [2:0] REG_MAX_TLVS    = 3'd3;
	localparam logic [2:0] REG_MAX_OBJECTS = 3'd4;
	localparam logic [2:0] REG_MAX_KIND    = 3'd5;
	localparam logic [2:0] REG_MAX_TLV_LEN = 3'd6;

	typedef struct packed {
		logic        frame_end;
		logic [1:0]  error_code;
		logic [31:0] word_e;
		logic [31:0] word_d;
		logic [31:0] word_c;
		logic [31:0] word_b;
		logic [31:0] word_a;
		logic [7:0]  object_index;
		logic [1:0]  record_kind;
	} record_t;

	typedef struct packed {
		logic [31:0] sync_low;
		logic [31:0] sync_high;
		logic [15:0] max_payload_bytes;
		logic [7:0]  max_tlv_count;
		logic [7:0]  max_object_count;
		logic [7:0]  max_tlv_kind;
		logic [15:0] max_tlv_bytes;
	} limits_t;
endpackage
`default_nettype wire

/* hdl/rtfp_front.sv */
// Front part of the radar TLV frame parser: sync hunt, header and TLV walk, one byte a cycle while byte_valid is high.
// Depends on rtfp_pkg; produces at most one record per accepted byte.
`default_nettype none
module rtfp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	input  wire logic [7:0]       rx_byte,
	input  wire rtfp_pkg::limits_t limits,
	output logic                  rec_valid,
	output rtfp_pkg::record_t     rec
);
	rtfp_pkg::phase_t phase_q, phase_d;
	logic [63:0] window_q, window_d;
	logic [7:0]  pos_q, pos_d;
	logic [31:0] word_q, word_d;
	logic [31:0] frame_q, frame_d, total_q, total_d, cycles_q, cycles_d;
	logic [7:0]  objects_q, objects_d, tlvs_q, tlvs_d, tlv_idx_q, tlv_idx_d;
	logic [31:0] kind_q, kind_d;
	logic [15:0] tlv_rem_q, tlv_rem_d, pay_rem_q, pay_rem_d;
	logic [7:0]  cursor_q, cursor_d;
	logic [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
	logic        fault_q, fault_d;

	always_comb begin
		logic [31:0] asm_w;
		logic [7:0]  pos_n;
		logic [31:0] pay_w;
		logic        flt;
		logic        done;
		logic        fin;
		phase_d = phase_q; window_d = window_q; pos_d = pos_q; word_d = word_q;
		frame_d = frame_q; total_d = total_q; cycles_d = cycles_q;
		objects_d = objects_q; tlvs_d = tlvs_q; tlv_idx_d = tlv_idx_q;
		kind_d = kind_q; tlv_rem_d = tlv_rem_q; pay_rem_d = pay_rem_q;
		cursor_d = cursor_q; pos_x_d = pos_x_q; pos_y_d = pos_y_q; pos_z_d = pos_z_q;
		fault_d = fault_q;
		rec_valid = 1'b0;
		rec = '0;
		asm_w = {rx_byte, word_q[31:8]};
		pos_n = pos_q + 8'd1;
		pay_w = '0;
		flt = fault_q;
		done = 1'b0;
		fin = 1'b0;
		unique case (phase_q)
			rtfp_pkg::PH_HUNT: begin
				window_d = {rx_byte, window_q[63:8]};
				if (pos_q < 8'd8) pos_d = pos_n;
				if ((pos_q >= 8'd7) && (window_d == {limits.sync_high, limits.sync_low})) begin
					phase_d = rtfp_pkg::PH_HEADER;
					pos_d = 8'd8;
					word_d = '0;
					fault_d = 1'b0;
				end
			end
			rtfp_pkg::PH_HEADER: begin
				word_d = asm_w;
				if (pos_q[1:0] == 2'd3) begin
					case (pos_q - 8'd3)
						8'd12: total_d = asm_w;
						8'd20: frame_d = asm_w;
						8'd24: cycles_d = asm_w;
						8'd28: begin
							if (asm_w > {24'd0, limits.max_object_count}) flt = 1'b1;
							objects_d = asm_w[7:0];
						end
						8'd32: begin
							if (asm_w > {24'd0, limits.max_tlv_count}) flt = 1'b1;
							tlvs_d = asm_w[7:0];
						end
						default: ;
					endcase
				end
				fault_d = flt;
				pos_d = pos_n;
				if (pos_n == 8'(rtfp_pkg::HEADER_BYTES)) begin
					if (total_d < 32'(rtfp_pkg::HEADER_BYTES)) begin
						flt = 1'b1;
					end else begin
						pay_w = total_d - 32'(rtfp_pkg::HEADER_BYTES);
						if (pay_w > {16'd0, limits.max_payload_bytes}) flt = 1'b1;
					end
					fault_d = flt;
					rec_valid = 1'b1;
					if (flt) begin
						pay_rem_d = '0;
						rec.record_kind = rtfp_pkg::KIND_ERROR;
						rec.error_code = rtfp_pkg::ERR_LIMITS;
						rec.frame_end = 1'b1;
						phase_d = rtfp_pkg::PH_HUNT;
						window_d = '0;
						pos_d = '0;
					end else begin
						pay_rem_d = pay_w[15:0];
						tlv_idx_d = '0;
						cursor_d = '0;
						pos_d = '0;
						rec.record_kind = rtfp_pkg::KIND_HEADER;
						rec.word_a = frame_d;
						rec.word_b = total_d;
						rec.word_c = {24'd0, objects_d};
						rec.word_d = {24'd0, tlvs_d};
						rec.word_e = cycles_d;
						if ((tlvs_d == 8'd0) || (pay_w[15:0] == 16'd0)) begin
							rec.frame_end = 1'b1;
							if (pay_w[15:0] != 16'd0) begin
								phase_d = rtfp_pkg::PH_SKIP;
							end else begin
								phase_d = rtfp_pkg::PH_HUNT;
								window_d = '0;
							end
						end else begin
							phase_d = rtfp_pkg::PH_TLV_HEAD;
						end
					end
				end
			end
			rtfp_pkg::PH_TLV_HEAD: begin
				word_d = asm_w;
				pay_rem_d = pay_rem_q - 16'd1;
				pos_d = pos_n;
				if (pos_n == 8'd4) begin
					kind_d = asm_w;
				end else if (pos_n >= 8'(rtfp_pkg::TLV_HEADER_BYTES)) begin
					pos_d = '0;
					cursor_d = '0;
					if ((kind_q > {24'd0, limits.max_tlv_kind}) ||
						(asm_w > {16'd0, limits.max_tlv_bytes})) begin
						rec_valid = 1'b1;
						rec.record_kind = rtfp_pkg::KIND_ERROR;
						rec.error_code = rtfp_pkg::ERR_TLV;
						rec.frame_end = 1'b1;
						if (pay_rem_d != 16'd0) begin
							phase_d = rtfp_pkg::PH_SKIP;
						end else begin
							phase_d = rtfp_pkg::PH_HUNT;
							window_d = '0;
						end
					end else begin
						tlv_rem_d = asm_w[15:0];
						if (asm_w[15:0] == 16'd0) done = 1'b1;
						else phase_d = rtfp_pkg::PH_TLV_BODY;
					end
				end
				fin = !rec_valid;
			end
			rtfp_pkg::PH_TLV_BODY: begin
				word_d = asm_w;
				pay_rem_d = pay_rem_q - 16'd1;
				tlv_rem_d = tlv_rem_q - 16'd1;
				if (kind_q == 32'd1) begin
					pos_d = pos_n;
					if (pos_n[1:0] == 2'd0) begin
						case (pos_n[4:2])
							3'd1: pos_x_d = asm_w;
							3'd2: pos_y_d = asm_w;
							3'd3: pos_z_d = asm_w;
							default: begin
								if (cursor_q < objects_q) begin
									rec_valid = 1'b1;
									rec.record_kind = rtfp_pkg::KIND_POSITION;
									rec.object_index = cursor_q;
									rec.word_a = pos_x_q;
									rec.word_b = pos_y_q;
									rec.word_c = pos_z_q;
									rec.word_d = asm_w;
								end
								if (cursor_q != 8'hFF) cursor_d = cursor_q + 8'd1;
								pos_d = '0;
							end
						endcase
					end
				end else if (kind_q == 32'd7) begin
					pos_d = pos_n;
					if (pos_n >= 8'd4) begin
						if (cursor_q < objects_q) begin
							rec_valid = 1'b1;
							rec.record_kind = rtfp_pkg::KIND_SNR;
							rec.object_index = cursor_q;
							rec.word_a = {16'd0, asm_w[15:0]};
							rec.word_b = {16'd0, asm_w[31:16]};
						end
						if (cursor_q != 8'hFF) cursor_d = cursor_q + 8'd1;
						pos_d = '0;
					end
				end
				if (tlv_rem_d == 16'd0) done = 1'b1;
				fin = 1'b1;
			end
			rtfp_pkg::PH_SKIP: begin
				pay_rem_d = pay_rem_q - 16'd1;
				if (pay_rem_d == 16'd0) begin
					phase_d = rtfp_pkg::PH_HUNT;
					window_d = '0;
					pos_d = '0;
				end
			end
			default: begin
				phase_d = rtfp_pkg::PH_HUNT;
				window_d = '0;
				pos_d = '0;
			end
		endcase
		if (fin) begin
			if (done) begin
				tlv_idx_d = tlv_idx_q + 8'd1;
				phase_d = rtfp_pkg::PH_TLV_HEAD;
				pos_d = '0;
			end
			if ((pay_rem_d == 16'd0) || (done && (tlv_idx_d == tlvs_q))) begin
				if (rec_valid) begin
					rec.frame_end = 1'b1;
				end else begin
					rec_valid = 1'b1;
					rec.record_kind = rtfp_pkg::KIND_ERROR;
					rec.error_code = rtfp_pkg::ERR_NONE;
					rec.frame_end = 1'b1;
				end
				if (pay_rem_d != 16'd0) begin
					phase_d = rtfp_pkg::PH_SKIP;
				end else begin
					phase_d = rtfp_pkg::PH_HUNT;
					window_d = '0;
					pos_d = '0;
				end
			end
		end
		if (!byte_valid) rec_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rtfp_pkg::PH_HUNT;
			window_q <= '0; pos_q <= '0; word_q <= '0;
			frame_q <= '0; total_q <= '0; cycles_q <= '0;
			objects_q <= '0; tlvs_q <= '0; tlv_idx_q <= '0;
			kind_q <= '0; tlv_rem_q <= '0; pay_rem_q <= '0; cursor_q <= '0;
			pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0; fault_q <= 1'b0;
		end else if (byte_valid) begin
			phase_q <= phase_d;
			window_q <= window_d; pos_q <= pos_d; word_q <= word_d;
			frame_q <= frame_d; total_q <= total_d; cycles_q <= cycles_d;
			objects_q <= objects_d; tlvs_q <= tlvs_d; tlv_idx_q <= tlv_idx_d;
			kind_q <= kind_d; tlv_rem_q <= tlv_rem_d; pay_rem_q <= pay_rem_d;
			cursor_q <= cursor_d;
			pos_x_q <= pos_x_d; pos_y_q <= pos_y_d; pos_z_q <= pos_z_d; fault_q <= fault_d;
		end
	end
endmodule
`default_nettype wire

/* hdl/rtfp_queue.sv */
// Short record queue between the parser front and the output back part.
// Depends on rtfp_pkg for the record type and depth.
`default_nettype none
module rtfp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rtfp_pkg::record_t push_rec,
	input  wire logic              pop,
	output logic                   full,
	output logic                   empty,
	output rtfp_pkg::record_t      head
);
	localparam int AW = $clog2(rtfp_pkg::QUEUE_DEPTH);
	rtfp_pkg::record_t mem_q [rtfp_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;

	assign full = (count_q == (AW+1)'(rtfp_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

/* hdl/rtfp_back.sv */
// Back part of the radar TLV frame parser: output register driving the master stream.
// Depends on rtfp_pkg for the record type.
`default_nettype none
module rtfp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire rtfp_pkg::record_t q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rtfp_pkg::record_t      out_rec
);
	logic valid_q;
	rtfp_pkg::record_t rec_q;

	assign q_pop = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || out_ready) valid_q <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (q_pop) rec_q <= q_head;
	end
endmodule
`default_nettype wire

/* hdl/radar_tlv_frame_parser.sv */
// Top level of the radar TLV frame parser.
// Instantiates rtfp_front, rtfp_queue and rtfp_back; depends on rtfp_pkg.
//
// Usage:
// Bytes of the radar output stream enter on s_tdata, one per transfer. The
// parser hunts for the sync word, reads the header and walks the TLVs, and
// each byte yields at most one record on the m_ channel: m_tuser is the
// record kind, m_tlast marks the last record of a frame.
// Registers are written through cfg_valid, cfg_index and cfg_data while the
// block is idle, a rule for the user that the block itself does not enforce;
// cfg_ready is always high. Throughput is one byte per cycle while s_tready
// is high, set by the per-byte parser state update. A record enters the queue
// at the edge that accepts its byte and the output register once it is free.
// The queue holds four records; when the receiver stalls, s_tready drops
// only once the queue is full, and no record is lost.
// Reset clears the parser to the sync hunt, empties the queue and loads the
// register reset values.
`default_nettype none
module radar_tlv_frame_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // rx_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [175:0]      m_tdata,   // object_index, word_a..word_e, error_code, zero fill
	output logic [1:0]        m_tuser,   // record_kind
	output logic              m_tlast,   // frame_end
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	rtfp_pkg::limits_t limits_q;
	rtfp_pkg::record_t front_rec, head_rec, out_rec;
	logic front_valid, q_full, q_empty, q_pop, accept;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.sync_low <= 32'd50594050;
			limits_q.sync_high <= 32'd117966086;
			limits_q.max_payload_bytes <= 16'd10000;
			limits_q.max_tlv_count <= 8'd20;
			limits_q.max_object_count <= 8'd10;
			limits_q.max_tlv_kind <= 8'd20;
			limits_q.max_tlv_bytes <= 16'd10000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtfp_pkg::REG_SYNC_LOW:    limits_q.sync_low <= cfg_data;
				rtfp_pkg::REG_SYNC_HIGH:   limits_q.sync_high <= cfg_data;
				rtfp_pkg::REG_MAX_PAYLOAD: limits_q.max_payload_bytes <= cfg_data[15:0];
				rtfp_pkg::REG_MAX_TLVS:    limits_q.max_tlv_count <= cfg_data[7:0];
				rtfp_pkg::REG_MAX_OBJECTS: limits_q.max_object_count <= cfg_data[7:0];
				rtfp_pkg::REG_MAX_KIND:    limits_q.max_tlv_kind <= cfg_data[7:0];
				rtfp_pkg::REG_MAX_TLV_LEN: limits_q.max_tlv_bytes <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rtfp_front u_front (
		.clk(clk), .arst_n(arst_n), .byte_valid(accept), .rx_byte(s_tdata),
		.limits(limits_q), .rec_valid(front_valid), .rec(front_rec)
	);

	rtfp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(front_valid), .push_rec(front_rec),
		.pop(q_pop), .full(q_full), .empty(q_empty), .head(head_rec)
	);

	rtfp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_head(head_rec), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_rec(out_rec)
	);

	assign m_tdata = {6'd0, out_rec.error_code, out_rec.word_e, out_rec.word_d,
		out_rec.word_c, out_rec.word_b, out_rec.word_a, out_rec.object_index};
	assign m_tuser = out_rec.record_kind;
	assign m_tlast = out_rec.frame_end;

	a_err_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == rtfp_pkg::KIND_ERROR)) |-> m_tlast)
		else $error("error record without frame end");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !front_valid)
		else $error("record produced while queue full");
	a_pop_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid)
		else $error("popped record did not reach the output");
	a_header_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != rtfp_pkg::KIND_ERROR)) |-> (m_tdata[169:168] == 2'd0))
		else $error("non-error record carries an error code");
endmodule
`default_nettype wire

/* dv/radar_tlv_frame_parser_test.sv */
// Self-checking testbench for radar_tlv_frame_parser: streams radar bytes, predicts records.
// Depends on rtfp_pkg and the parser RTL; a scoreboard class holds the prediction state.
`timescale 1ns / 100ps
`default_nettype none

class frame_record_board;
	logic [31:0] sync_lo, sync_hi;
	logic [15:0] lim_payload, lim_tlv_len;
	logic [7:0] lim_tlvs, lim_objects, lim_kind;
	rtfp_pkg::phase_t phase;
	logic [63:0] window;
	logic [31:0] pos, assembly, frame_no, total_len, cycles, kind, tlv_left, payload_left;
	logic [7:0] obj_count, tlv_count, tlv_idx, cursor;
	logic [31:0] pwords[3];
	bit fault;
	rtfp_pkg::record_t pending[$];
	int mismatches;

	function new();
		sync_lo = 32'h03040102;
		sync_hi = 32'h07080506;
		lim_payload = 10000;
		lim_tlvs = 20;
		lim_objects = 10;
		lim_kind = 20;
		lim_tlv_len = 10000;
		phase = rtfp_pkg::PH_HUNT;
		window = 0;
		pos = 0;
		assembly = 0;
		frame_no = 0;
		total_len = 0;
		cycles = 0;
		kind = 0;
		tlv_left = 0;
		payload_left = 0;
		obj_count = 0;
		tlv_count = 0;
		tlv_idx = 0;
		cursor = 0;
		pwords[0] = 0;
		pwords[1] = 0;
		pwords[2] = 0;
		fault = 0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			rtfp_pkg::REG_SYNC_LOW: sync_lo = val;
			rtfp_pkg::REG_SYNC_HIGH: sync_hi = val;
			rtfp_pkg::REG_MAX_PAYLOAD: lim_payload = val[15:0];
			rtfp_pkg::REG_MAX_TLVS: lim_tlvs = val[7:0];
			rtfp_pkg::REG_MAX_OBJECTS: lim_objects = val[7:0];
			rtfp_pkg::REG_MAX_KIND: lim_kind = val[7:0];
			rtfp_pkg::REG_MAX_TLV_LEN: lim_tlv_len = val[15:0];
			default: ;
		endcase
	endfunction

	function rtfp_pkg::record_t make(logic [1:0] rk, logic [7:0] idx, logic [31:0] a,
			logic [31:0] b, logic [31:0] c, logic [31:0] d, logic [31:0] e,
			logic [1:0] code, logic fe);
		rtfp_pkg::record_t r;
		r.record_kind = rk;
		r.object_index = idx;
		r.word_a = a;
		r.word_b = b;
		r.word_c = c;
		r.word_d = d;
		r.word_e = e;
		r.error_code = code;
		r.frame_end = fe;
		return r;
	endfunction

	function void start_hunt();
		phase = rtfp_pkg::PH_HUNT;
		window = 0;
		pos = 0;
	endfunction

	function void finish_walk();
		if (payload_left != 0) phase = rtfp_pkg::PH_SKIP;
		else start_hunt();
	endfunction

	function void note_byte(logic [7:0] x);
		rtfp_pkg::record_t r;
		bit have, tlv_done;
		logic [31:0] k;
		have = 0;
		tlv_done = 0;
		case (phase)
			rtfp_pkg::PH_HUNT: begin
				window = {x, window[63:8]};
				if (pos < 8) pos++;
				if (pos >= 8 && window == {sync_hi, sync_lo}) begin
					phase = rtfp_pkg::PH_HEADER;
					pos = 8;
					assembly = 0;
					fault = 0;
				end
				return;
			end
			rtfp_pkg::PH_HEADER: begin
				assembly = {x, assembly[31:8]};
				if (pos[1:0] == 2'd3) begin
					case (pos - 3)
						12: total_len = assembly;
						20: frame_no = assembly;
						24: cycles = assembly;
						28: begin
							if (assembly > lim_objects) fault = 1;
							obj_count = assembly[7:0];
						end
						32: begin
							if (assembly > lim_tlvs) fault = 1;
							tlv_count = assembly[7:0];
						end
						default: ;
					endcase
				end
				pos++;
				if (pos < rtfp_pkg::HEADER_BYTES) return;
				if (total_len < rtfp_pkg::HEADER_BYTES) fault = 1;
				else payload_left = total_len - rtfp_pkg::HEADER_BYTES;
				if (!fault && payload_left > lim_payload) fault = 1;
				if (fault) begin
					payload_left = 0;
					pending = {pending, make(rtfp_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
						rtfp_pkg::ERR_LIMITS, 1)};
					start_hunt();
					return;
				end
				tlv_idx = 0;
				cursor = 0;
				pos = 0;
				if (tlv_count == 0 || payload_left == 0) begin
					pending = {pending, make(rtfp_pkg::KIND_HEADER, 0, frame_no, total_len,
						obj_count, tlv_count, cycles, rtfp_pkg::ERR_NONE, 1)};
					finish_walk();
				end else begin
					pending = {pending, make(rtfp_pkg::KIND_HEADER, 0, frame_no, total_len,
						obj_count, tlv_count, cycles, rtfp_pkg::ERR_NONE, 0)};
					phase = rtfp_pkg::PH_TLV_HEAD;
				end
				return;
			end
			rtfp_pkg::PH_TLV_HEAD: begin
				assembly = {x, assembly[31:8]};
				payload_left--;
				pos++;
				if (pos == 4) kind = assembly;
				else if (pos >= rtfp_pkg::TLV_HEADER_BYTES) begin
					pos = 0;
					cursor = 0;
					if (kind > lim_kind || assembly > lim_tlv_len) begin
						pending = {pending, make(rtfp_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0,
							rtfp_pkg::ERR_TLV, 1)};
						finish_walk();
						return;
					end
					tlv_left = assembly;
					if (tlv_left == 0) tlv_done = 1;
					else phase = rtfp_pkg::PH_TLV_BODY;
				end
			end
			rtfp_pkg::PH_TLV_BODY: begin
				assembly = {x, assembly[31:8]};
				payload_left--;
				tlv_left--;
				if (kind == 1) begin
					pos++;
					if (pos[1:0] == 0) begin
						k = (pos >> 2) - 1;
						if (k < 3) pwords[k] = assembly;
						else begin
							if (cursor < obj_count) begin
								r = make(rtfp_pkg::KIND_POSITION, cursor, pwords[0], pwords[1],
									pwords[2], assembly, 0, rtfp_pkg::ERR_NONE, 0);
								have = 1;
							end
							if (cursor < 255) cursor++;
							pos = 0;
						end
					end
				end else if (kind == 7) begin
					pos++;
					if (pos >= 4) begin
						if (cursor < obj_count) begin
							r = make(rtfp_pkg::KIND_SNR, cursor, {16'd0, assembly[15:0]},
								{16'd0, assembly[31:16]}, 0, 0, 0, rtfp_pkg::ERR_NONE, 0);
							have = 1;
						end
						if (cursor < 255) cursor++;
						pos = 0;
					end
				end
				if (tlv_left == 0) tlv_done = 1;
			end
			rtfp_pkg::PH_SKIP: begin
				payload_left--;
				if (payload_left == 0) start_hunt();
				return;
			end
			default: begin
				start_hunt();
				return;
			end
		endcase
		if (tlv_done) begin
			tlv_idx++;
			phase = rtfp_pkg::PH_TLV_HEAD;
			pos = 0;
		end
		if (payload_left == 0 || (tlv_done && tlv_idx == tlv_count)) begin
			if (have) r.frame_end = 1;
			else r = make(rtfp_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, rtfp_pkg::ERR_NONE, 1);
			have = 1;
			finish_walk();
		end
		if (have) pending = {pending, r};
	endfunction

	function void check_record(rtfp_pkg::record_t got);
		rtfp_pkg::record_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("Unexpected record %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Record mismatch: kind %0d/%0d idx %0d/%0d code %0d/%0d end %0d/%0d",
					want.record_kind, got.record_kind, want.object_index, got.object_index,
					want.error_code, got.error_code, want.frame_end, got.frame_end);
				$display("  words exp %h %h %h %h %h", want.word_a, want.word_b, want.word_c,
					want.word_d, want.word_e);
				$display("  words got %h %h %h %h %h", got.word_a, got.word_b, got.word_c,
					got.word_d, got.word_e);
			end
		end
	endfunction
endclass

module radar_tlv_frame_parser_test;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [175:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	frame_record_board board = new();
	logic [7:0] byte_stream[$];
	int idle_pct = 36;
	int stall_pct = 36;
	logic hold_rx = 0;
	logic [31:0] cur_sync_lo = 32'h03040102;
	logic [31:0] cur_sync_hi = 32'h07080506;

	radar_tlv_frame_parser DUT (.*);

	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		rtfp_pkg::record_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata[169:168], m_tdata[167:8], m_tdata[7:0], m_tuser};
			board.check_record(got);
		end
		if (hold_rx) m_tready <= 0;
		else m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic hold_receiver(int cycles);
		hold_rx <= 1;
		repeat (cycles) @(posedge clk);
		hold_rx <= 0;
	endtask

	task automatic send_byte(logic [7:0] x);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= x;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_byte(x);
	endtask

	task automatic flush_stream();
		while (byte_stream.size() > 0) send_byte(byte_stream.pop_front());
	endtask

	task automatic drain();
		int n;
		n = 0;
		s_tvalid <= 0;
		while (board.pending.size() > 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, val);
		if (idx == rtfp_pkg::REG_SYNC_LOW) cur_sync_lo = val;
		if (idx == rtfp_pkg::REG_SYNC_HIGH) cur_sync_hi = val;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++) byte_stream = {byte_stream, w[8*i +: 8]};
	endtask

	// Builds one frame: sync, header, then TLVs with optional corruption, padding and length adjustment.
	task automatic build_frame(int n_obj, int n_tlv, bit bad_tlv, int pad, int len_adj);
		logic [7:0] body[$];
		int tlen, knd, cnt, blen;
		for (int t = 0; t < n_tlv; t++) begin
			case ($urandom_range(5))
				0, 1: knd = 1;
				2, 3: knd = 7;
				4: knd = $urandom_range(20);
				default: knd = $urandom_range(255);
			endcase
			cnt = n_obj + $urandom_range(2) - 1;
			if (cnt < 0) cnt = 0;
			blen = (knd == 1) ? 16 * cnt : (knd == 7) ? 4 * cnt : $urandom_range(12);
			if ($urandom_range(7) == 0) blen += $urandom_range(3);
			if (bad_tlv && t == n_tlv - 1) begin
				if ($urandom_range(1)) knd = 21 + $urandom_range(234);
				else blen = 10001 + $urandom_range(100);
			end
			for (int i = 0; i < 4; i++) body = {body, 8'(knd >> (8 * i))};
			for (int i = 0; i < 4; i++) body = {body, 8'(blen >> (8 * i))};
			if (!(bad_tlv && t == n_tlv - 1))
				for (int i = 0; i < blen; i++) body = {body, 8'($urandom)};
		end
		for (int i = 0; i < pad; i++) body = {body, 8'($urandom)};
		tlen = 40 + body.size() + len_adj;
		put_word(cur_sync_lo);
		put_word(cur_sync_hi);
		put_word($urandom);
		put_word(tlen);
		put_word($urandom);
		put_word($urandom);
		put_word($urandom);
		put_word(n_obj);
		put_word(n_tlv);
		put_word($urandom);
		foreach (body[i]) byte_stream = {byte_stream, body[i]};
	endtask

	task automatic random_frames(int count);
		int r;
		for (int f = 0; f < count; f++) begin
			r = $urandom_range(19);
			if (r == 0)
				repeat ($urandom_range(12)) byte_stream = {byte_stream, 8'($urandom)};
			else if (r == 1) build_frame($urandom_range(12), $urandom_range(22), 0, 0, 0);
			else if (r == 2) build_frame($urandom_range(4), 1 + $urandom_range(3), 1, 0, 0);
			else if (r == 3)
				build_frame($urandom_range(3), 1 + $urandom_range(2), 0, 0,
					-int'($urandom_range(10)));
			else
				build_frame($urandom_range(4), $urandom_range(3), 0,
					($urandom_range(3) == 0) ? $urandom_range(6) : 0, 0);
			flush_stream();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed frames: empty, two random TLVs with padding, TLV error, limit errors, short length.
		build_frame(0, 0, 0, 0, 0);
		build_frame(2, 2, 0, 3, 0);
		build_frame(1, 2, 1, 0, 0);
		build_frame(11, 0, 0, 0, 0);
		build_frame(0, 21, 0, 0, 0);
		put_word(cur_sync_lo);
		put_word(cur_sync_hi);
		repeat (4) put_word(32'hFFFFFFFF);
		repeat (4) put_word(0);
		put_word(cur_sync_lo);
		put_word(cur_sync_hi);
		repeat (8) put_word(0);
		byte_stream = {byte_stream, 8'h00};
		byte_stream = {byte_stream, 8'hFF};
		flush_stream();

		// Receiver holds off long while the sender keeps going.
		fork
			hold_receiver(300);
		join_none
		build_frame(4, 2, 0, 0, 0);
		flush_stream();
		drain();

		random_frames(1);
		drain();
		write_reg(rtfp_pkg::REG_SYNC_LOW, 32'hFFFFFFFF);
		write_reg(rtfp_pkg::REG_SYNC_HIGH, 32'h00000000);
		write_reg(rtfp_pkg::REG_MAX_PAYLOAD, 32'd65535);
		write_reg(rtfp_pkg::REG_MAX_TLVS, 32'd255);
		write_reg(rtfp_pkg::REG_MAX_OBJECTS, 32'd255);
		write_reg(rtfp_pkg::REG_MAX_KIND, 32'd255);
		write_reg(rtfp_pkg::REG_MAX_TLV_LEN, 32'd65535);
		idle_pct = 0;
		stall_pct = 0;
		random_frames(2);
		drain();
		idle_pct = 36;
		stall_pct = 36;
		write_reg(rtfp_pkg::REG_SYNC_LOW, $urandom);
		write_reg(rtfp_pkg::REG_SYNC_HIGH, $urandom);
		write_reg(rtfp_pkg::REG_MAX_PAYLOAD, 32'd0);
		write_reg(rtfp_pkg::REG_MAX_TLVS, 32'd0);
		write_reg(rtfp_pkg::REG_MAX_OBJECTS, 32'd0);
		write_reg(rtfp_pkg::REG_MAX_KIND, 32'd0);
		write_reg(rtfp_pkg::REG_MAX_TLV_LEN, 32'd0);
		random_frames(1);
		drain();
		write_reg(rtfp_pkg::REG_MAX_PAYLOAD, 32'd200);
		write_reg(rtfp_pkg::REG_MAX_TLVS, 32'd4);
		write_reg(rtfp_pkg::REG_MAX_OBJECTS, 32'd3);
		write_reg(rtfp_pkg::REG_MAX_KIND, 32'd7);
		write_reg(rtfp_pkg::REG_MAX_TLV_LEN, 32'd60);
		random_frames(2);
		drain();
		flush_stream();
		drain();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

/* sim.f */
hdl/rtfp_pkg.sv
hdl/rtfp_front.sv
hdl/rtfp_queue.sv
hdl/rtfp_back.sv
hdl/radar_tlv_frame_parser.sv
dv/radar_tlv_frame_parser_test.sv
